// ===== design/led_fade_pattern_sequencer_unit_assert.svh =====
// led_fade_pattern_sequencer_unit_assert.svh: assertion macros for the led fade sequencer
// used by the port checker; no other dependencies
`ifndef LED_FADE_PATTERN_SEQUENCER_UNIT_ASSERT_SVH
`define LED_FADE_PATTERN_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication, skipped while reset is low
`define LFPS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("led fade sequencer: same-cycle check failed");

// next-cycle implication, skipped while reset is low
`define LFPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("led fade sequencer: next-cycle check failed");

`endif

// ===== design/lfps_pkg.sv =====
// lfps_pkg.sv: shared types, codes and constants of the led fade pattern sequencer
// no dependencies
`timescale 1ns / 1ps

package lfps_pkg;

  // event kinds on the input word
  typedef enum logic [1:0] {
    EV_SLOT   = 2'd0,
    EV_TIMER  = 2'd1,
    EV_BUTTON = 2'd2,
    EV_NONE   = 2'd3
  } lfps_event_t;

  // light modes
  localparam logic [2:0] MODE_OFF     = 3'd0;
  localparam logic [2:0] MODE_ON      = 3'd1;
  localparam logic [2:0] MODE_SLOW    = 3'd2;
  localparam logic [2:0] MODE_FAST    = 3'd3;
  localparam logic [2:0] MODE_CHASE   = 3'd4;
  localparam logic [2:0] MODE_SEQ     = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_IDLE_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_HOLD_MIN     = 2'd1;
  localparam logic [1:0] CFG_HOLD_MAX     = 2'd2;
  localparam logic [1:0] CFG_SLOW_STRETCH = 2'd3;

  // register reset values
  localparam logic [8:0] IDLE_TIMEOUT_RST = 9'd300;
  localparam logic [8:0] HOLD_MIN_RST     = 9'd3;
  localparam logic [8:0] HOLD_MAX_RST     = 9'd9;
  localparam logic [3:0] SLOW_STRETCH_RST = 4'd3;

  // pattern shape
  localparam logic [7:0] FULL_LEVEL    = 8'd255;
  localparam logic [7:0] BREATHE_STEP  = 8'd4;
  localparam logic [7:0] BREATHE_TOP   = 8'd248;
  localparam logic [7:0] BREATHE_FLOOR = 8'd5;
  localparam logic [7:0] CHASE_STEP    = 8'd10;
  localparam logic [7:0] CHASE_END     = 8'd240;
  localparam logic [7:0] CHASE_HOLD    = 8'd100;
  localparam logic [7:0] SEQ_STEP      = 8'd2;
  localparam logic [7:0] SEQ_LAST      = 8'd253;
  localparam logic [7:0] SEQ_HOLD      = 8'd5;
  localparam int unsigned SEQ_DIR_POS  = 5;
  localparam logic [9:0] IDLE_RST      = 10'h3FF;

  // fade sequence table: led mask in the low bits, direction in bit five
  function automatic logic [7:0] fade_entry(input logic [2:0] idx);
    logic [7:0] e;
    unique case (idx)
      3'd0:    e = 8'd36;
      3'd1:    e = 8'd42;
      3'd2:    e = 8'd49;
      3'd3:    e = 8'd17;
      3'd4:    e = 8'd10;
      3'd5:    e = 8'd4;
      default: e = 8'd0;
    endcase
    return e;
  endfunction

endpackage

// ===== design/led_fade_pattern_sequencer_unit.sv =====
// led_fade_pattern_sequencer_unit.sv: soft-pwm led pattern sequencer, top level
// depends on lfps_pkg
`timescale 1ns / 1ps

// Usage
// - in channel: one word per event (slot tick, timer tick, button edge) with the
//   button pin level; in_valid/in_ready handshake
// - out channel: one word per accepted event with the led lines for that slot,
//   the light mode and the sleep flag after the event; out_valid/out_ready
// - cfg port: idle timeout, hold window limits and slow stretch, written by
//   index with cfg_we while no event is in flight; no read-back
// Timing
// - every event is handled in one pass of logic between the input handshake and
//   the output register: the word appears in the cycle after acceptance
// - one event per clock sustained while out_ready is high; in_ready stays high
//   while the output register is empty or being taken in the same cycle
// Reset (rst_n low, synchronous): mode off, all levels and pattern counters
//   cleared, idle count at all ones, sleep clear, registers at their defaults
// Stall: with out_ready low the held word stays on the output and in_ready drops
//   until it is taken; no event is lost or repeated

module led_fade_pattern_sequencer_unit #(
  parameter int LED_COUNT  = 5,
  parameter int PWM_STEPS  = 255,
  parameter int SEQ_LENGTH = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_mode,
  input  logic                   in_button_level,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [LED_COUNT-1:0]   out_led_lines,
  output logic [2:0]             out_light_mode,
  output logic                   out_asleep,
  // configuration port
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [8:0]             cfg_wdata
);

  import lfps_pkg::*;

  // configuration registers
  logic [8:0] idle_timeout_r;
  logic [8:0] hold_min_r;
  logic [8:0] hold_max_r;
  logic [3:0] slow_stretch_r;

  // pattern state
  logic [2:0] mode_r,   mode_nxt;
  logic [7:0] levels_r   [LED_COUNT];
  logic [7:0] levels_nxt [LED_COUNT];
  logic [7:0] slot_r,   slot_nxt;
  logic [6:0] repeat_r, repeat_nxt;
  logic [7:0] ramp_r,   ramp_nxt;
  logic [1:0] phase_r,  phase_nxt;
  logic [2:0] lead_r,   lead_nxt;
  logic [2:0] trail_r,  trail_nxt;
  logic [2:0] step_r,   step_nxt;
  logic [9:0] idle_r,   idle_nxt;
  logic       sleep_r,  sleep_nxt;

  // output register
  logic                 out_valid_r;
  logic [LED_COUNT-1:0] lines_r, lines_nxt;
  logic [2:0]           light_mode_r;
  logic                 asleep_r;

  logic accept;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_led_lines  = lines_r;
  assign out_light_mode = light_mode_r;
  assign out_asleep     = asleep_r;

  // event processing
  always_comb begin
    lfps_event_t kind;
    logic [8:0]  slot_inc;
    logic        wrap;
    logic [7:0]  rep_inc;
    logic [7:0]  hold_len;
    logic        advance;
    logic [7:0]  r;
    logic [7:0]  up_v;
    logic [7:0]  down_v;
    logic        set_lead;
    logic        set_trail;
    logic        set_mask;
    logic [7:0]  lead_v;
    logic [7:0]  trail_v;
    logic [7:0]  entry;
    logic [3:0]  lead_inc;
    logic [3:0]  step_inc;
    logic [9:0]  idle_inc;
    logic        force_off;
    logic        restart;

    kind      = lfps_event_t'(in_mode);
    mode_nxt  = mode_r;
    slot_nxt  = slot_r;
    repeat_nxt = repeat_r;
    ramp_nxt  = ramp_r;
    phase_nxt = phase_r;
    lead_nxt  = lead_r;
    trail_nxt = trail_r;
    step_nxt  = step_r;
    idle_nxt  = idle_r;
    sleep_nxt = sleep_r;
    levels_nxt = levels_r;
    lines_nxt = '0;
    restart   = 1'b0;
    r         = '0;
    up_v      = '0;
    down_v    = '0;
    set_lead  = 1'b0;
    set_trail = 1'b0;
    set_mask  = 1'b0;
    lead_v    = '0;
    trail_v   = '0;
    entry     = '0;

    // slot timing
    slot_inc = {1'b0, slot_r} + 9'd1;
    wrap     = (slot_inc >= 9'(PWM_STEPS));
    rep_inc  = {1'b0, repeat_r} + 8'd1;
    unique case (mode_r)
      MODE_SLOW:  hold_len = (slow_stretch_r == 4'd0) ? 8'd1 : {4'd0, slow_stretch_r};
      MODE_CHASE: hold_len = (phase_r == 2'd1) ? CHASE_HOLD : 8'd1;
      MODE_SEQ:   hold_len = (phase_r == 2'd1) ? SEQ_HOLD : 8'd1;
      default:    hold_len = 8'd1;
    endcase
    advance  = wrap && (rep_inc >= hold_len);
    lead_inc = {1'b0, lead_r} + 4'd1;
    step_inc = {1'b0, step_r} + 4'd1;

    // timer window
    idle_inc  = idle_r + 10'd1;
    force_off = (idle_inc >= {1'b0, idle_timeout_r}) ||
                (!in_button_level && (idle_inc >= {1'b0, hold_min_r}) &&
                 (idle_inc <= {1'b0, hold_max_r}));

    unique case (kind)
      EV_SLOT: begin
        // pwm compare against the current levels; all lines on in on mode
        if (mode_r == MODE_ON) begin
          lines_nxt = '1;
        end else if (mode_r >= MODE_SLOW && mode_r <= MODE_SEQ) begin
          for (int n = 0; n < LED_COUNT; n++) begin
            lines_nxt[n] = (levels_r[n] > slot_r);
          end
        end
        slot_nxt = wrap ? 8'd0 : slot_inc[7:0];
        if (wrap) begin
          repeat_nxt = advance ? 7'd0 : rep_inc[6:0];
        end
        // step the pattern at the end of a hold
        if (advance) begin
          unique case (mode_r)
            MODE_SLOW, MODE_FAST: begin
              if (phase_r == 2'd0) begin
                r = ramp_r + BREATHE_STEP;
                if (r >= BREATHE_TOP) phase_nxt = 2'd1;
              end else if (phase_r == 2'd1) begin
                phase_nxt = 2'd2;
                r = FULL_LEVEL;
              end else begin
                r = ramp_r - BREATHE_STEP;
                if (r <= BREATHE_FLOOR) begin
                  phase_nxt = 2'd0;
                  r = 8'd0;
                end
              end
              ramp_nxt = r;
              for (int n = 0; n < LED_COUNT; n++) levels_nxt[n] = r;
            end
            MODE_CHASE: begin
              if (phase_r == 2'd0) begin
                r = ramp_r + CHASE_STEP;
                ramp_nxt = r;
                if (r < CHASE_END) begin
                  lead_v  = r;
                  trail_v = FULL_LEVEL - r;
                end else begin
                  phase_nxt = 2'd1;
                  lead_v  = FULL_LEVEL;
                  trail_v = 8'd0;
                end
              end else begin
                trail_nxt = lead_r;
                lead_nxt  = (lead_inc >= 4'(LED_COUNT)) ? 3'd0 : lead_inc[2:0];
                phase_nxt = 2'd0;
                ramp_nxt  = 8'd0;
                lead_v    = 8'd0;
                trail_v   = FULL_LEVEL;
              end
              set_lead  = 1'b1;
              set_trail = (trail_nxt != lead_nxt);
            end
            MODE_SEQ: begin
              if (phase_r == 2'd0) begin
                r = ramp_r + SEQ_STEP;
                ramp_nxt = r;
                if (r <= SEQ_LAST) begin
                  up_v   = r;
                  down_v = FULL_LEVEL - r;
                end else begin
                  phase_nxt = 2'd1;
                  up_v   = FULL_LEVEL;
                  down_v = 8'd0;
                end
              end else begin
                step_nxt  = (step_inc >= 4'(SEQ_LENGTH)) ? 3'd0 : step_inc[2:0];
                phase_nxt = 2'd0;
                ramp_nxt  = 8'd0;
                up_v      = 8'd0;
                down_v    = FULL_LEVEL;
              end
              set_mask = 1'b1;
            end
            default: begin
            end
          endcase
          // chaser and masked level writes
          entry = fade_entry(step_nxt);
          for (int n = 0; n < LED_COUNT; n++) begin
            if (set_lead && lead_nxt == 3'(n)) begin
              levels_nxt[n] = lead_v;
            end else if (set_trail && trail_nxt == 3'(n)) begin
              levels_nxt[n] = trail_v;
            end
            if (set_mask && entry[n]) begin
              levels_nxt[n] = entry[SEQ_DIR_POS] ? up_v : down_v;
            end
          end
        end
      end
      EV_TIMER: begin
        // idle timeout and long press
        if (force_off) begin
          sleep_nxt = 1'b1;
          mode_nxt  = MODE_OFF;
          restart   = 1'b1;
          idle_nxt  = IDLE_RST;
        end else begin
          idle_nxt  = idle_inc;
        end
      end
      EV_BUTTON: begin
        // a release steps the mode, or wakes from sleep
        if (in_button_level) begin
          if (!sleep_r) begin
            mode_nxt = (mode_r >= MODE_SEQ) ? MODE_OFF : mode_r + 3'd1;
            restart  = 1'b1;
          end else begin
            sleep_nxt = 1'b0;
          end
        end
        idle_nxt = IDLE_RST;
      end
      EV_NONE: begin
      end
    endcase

    // mode change aborts the running pattern
    if (restart) begin
      for (int n = 0; n < LED_COUNT; n++) levels_nxt[n] = 8'd0;
      slot_nxt   = 8'd0;
      repeat_nxt = 7'd0;
      ramp_nxt   = 8'd0;
      phase_nxt  = 2'd0;
      lead_nxt   = 3'd0;
      trail_nxt  = 3'd0;
      step_nxt   = 3'd0;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_timeout_r <= IDLE_TIMEOUT_RST;
      hold_min_r     <= HOLD_MIN_RST;
      hold_max_r     <= HOLD_MAX_RST;
      slow_stretch_r <= SLOW_STRETCH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDLE_TIMEOUT: idle_timeout_r <= cfg_wdata;
        CFG_HOLD_MIN:     hold_min_r     <= cfg_wdata;
        CFG_HOLD_MAX:     hold_max_r     <= cfg_wdata;
        CFG_SLOW_STRETCH: slow_stretch_r <= cfg_wdata[3:0];
      endcase
    end
  end

  // pattern state update on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_OFF;
      slot_r   <= '0;
      repeat_r <= '0;
      ramp_r   <= '0;
      phase_r  <= '0;
      lead_r   <= '0;
      trail_r  <= '0;
      step_r   <= '0;
      idle_r   <= IDLE_RST;
      sleep_r  <= 1'b0;
      for (int n = 0; n < LED_COUNT; n++) levels_r[n] <= '0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      slot_r   <= slot_nxt;
      repeat_r <= repeat_nxt;
      ramp_r   <= ramp_nxt;
      phase_r  <= phase_nxt;
      lead_r   <= lead_nxt;
      trail_r  <= trail_nxt;
      step_r   <= step_nxt;
      idle_r   <= idle_nxt;
      sleep_r  <= sleep_nxt;
      levels_r <= levels_nxt;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      lines_r      <= lines_nxt;
      light_mode_r <= mode_nxt;
      asleep_r     <= sleep_nxt;
    end
  end

endmodule

// ===== design/lfps_port_checker.sv =====
// lfps_port_checker.sv: port-level checks on the led fade sequencer, bound to the top level
// depends on led_fade_pattern_sequencer_unit_assert.svh and lfps_pkg
`timescale 1ns / 1ps

`include "led_fade_pattern_sequencer_unit_assert.svh"

module lfps_port_checker #(
  parameter int LED_COUNT = 5
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [LED_COUNT-1:0] out_led_lines,
  input logic [2:0]           out_light_mode,
  input logic                 out_asleep
);

  import lfps_pkg::*;

  // every accepted word shows up on the output next cycle
  `LFPS_ASSERT_NEXT(a_word_out, clk, rst_n, in_valid && in_ready, out_valid)

  // a stalled result word holds
  `LFPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                    out_valid && $stable(out_led_lines) && $stable(out_light_mode))

  // off mode drives no led
  `LFPS_ASSERT_NOW(a_off_dark, clk, rst_n, out_valid && out_light_mode == MODE_OFF,
                   out_led_lines == '0)

  // sleep is only ever seen with the block off
  `LFPS_ASSERT_NOW(a_sleep_off, clk, rst_n, out_valid && out_asleep,
                   out_light_mode == MODE_OFF)

endmodule

bind led_fade_pattern_sequencer_unit lfps_port_checker #(
  .LED_COUNT(LED_COUNT)
) u_lfps_port_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_led_lines  (out_led_lines),
  .out_light_mode (out_light_mode),
  .out_asleep     (out_asleep)
);
